@@ design/sorted_table_binary_search_top_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define STBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define STBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/stbs_pkg.sv @@
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ENTRY_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // Bounds run from 0 to TABLE_DEPTH inclusive.
    localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_W     = 11;
    localparam int INDEX_W     = 10;
    localparam int VALUE_W     = 32;
    localparam int OUT_W       = 11;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic [OUT_W-1:0] NOT_FOUND = {OUT_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_PROBE   = 4'b0010,
        S_COMPARE = 4'b0100,
        S_FINISH  = 4'b1000
    } t_state;

endpackage

@@ design/sorted_table_binary_search_top.sv @@
// Binary search over a table of signed entries that software keeps in
// ascending order. A write request (req_type 0) stores entry_value at
// entry_index and produces no result. A search request (req_type 1)
// probes entries 0 to entry_count-1 in the usual low + (high-low)/2
// order and returns the index of the first matching probe, or -1 when
// nothing matches or the table is empty. Each probe passes through
// S_PROBE, which issues the registered read of the single-port table
// memory, and S_COMPARE, which narrows the bounds. A full table of 1024
// entries takes at most eleven probes. The request side is not ready
// while a search runs and is ready again in the cycle after the result
// is loaded. The result sits in an output register, so the next request
// can be taken while it waits to be picked up; a search that finishes
// while that register is still full waits until it empties. entry_count
// is written through its own port, which is always ready; the user must
// write it only while the block is idle, as the block does not enforce
// this. A count above the table depth searches the whole table. Table
// contents are undefined until written and need no clearing after reset.
module sorted_table_binary_search_top
    import stbs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_req_type,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic signed [VALUE_W-1:0] i_search_key,
    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [OUT_W-1:0]   o_match_index,
    // Configuration channel for entry_count.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [COUNT_W-1:0]        i_cfg_data
);

    t_state                 r_state, n_state;
    logic [COUNT_W-1:0]     r_entry_count;
    logic                   r_out_valid, n_out_valid;

    // Search datapath; no reset is needed on these.
    logic [BOUND_W-1:0]     r_low, n_low;
    logic [BOUND_W-1:0]     r_high_ex, n_high_ex;     // high + 1
    logic [ADDR_W-1:0]      r_mid, n_mid;
    logic [ENTRY_WIDTH-1:0] r_key, n_key;
    logic [OUT_W-1:0]       r_result, n_result;
    logic [OUT_W-1:0]       r_out_index, n_out_index;

    logic                   in_xfer;
    logic                   out_free;
    logic [BOUND_W-1:0]     count_clamped;
    logic [BOUND_W-1:0]     span;
    logic [BOUND_W-1:0]     mid_full;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    // A count beyond the table depth covers the whole table.
    assign count_clamped = (32'(r_entry_count) > TABLE_DEPTH) ? BOUND_W'(TABLE_DEPTH)
                                                              : BOUND_W'(r_entry_count);

    // With an exclusive upper bound, high - low equals high_ex - low - 1,
    // which is never negative while a probe is pending.
    assign span     = r_high_ex - r_low - BOUND_W'(1);
    assign mid_full = r_low + (span >> 1);

    // Writes land only while idle, at entry_index; outside idle the port reads at mid.
    assign ram_we   = in_xfer && (i_req_type == REQ_WRITE)
                      && (32'(i_entry_index) < TABLE_DEPTH);
    assign ram_addr = (r_state == S_IDLE) ? ADDR_W'(i_entry_index) : ADDR_W'(mid_full);

    stbs_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_WIDTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_entry_value[ENTRY_WIDTH-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_low       = r_low;
        n_high_ex   = r_high_ex;
        n_mid       = r_mid;
        n_key       = r_key;
        n_result    = r_result;
        n_out_index = r_out_index;

        // A pending result leaves once its transfer completes.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_req_type == REQ_SEARCH)) begin
                    n_low     = '0;
                    n_high_ex = count_clamped;
                    n_key     = i_search_key[ENTRY_WIDTH-1:0];
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                // The read at mid is issued in this cycle.
                if (r_low < r_high_ex) begin
                    n_mid   = ADDR_W'(mid_full);
                    n_state = S_COMPARE;
                end else begin
                    n_result = NOT_FOUND;
                    n_state  = S_FINISH;
                end
            end
            S_COMPARE: begin
                if (ram_rdata == r_key) begin
                    n_result = OUT_W'(r_mid);
                    n_state  = S_FINISH;
                end else if ($signed(r_key) < $signed(ram_rdata)) begin
                    n_high_ex = BOUND_W'(r_mid);
                    n_state   = S_PROBE;
                end else begin
                    n_low   = BOUND_W'(r_mid) + BOUND_W'(1);
                    n_state = S_PROBE;
                end
            end
            S_FINISH: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_entry_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low       <= n_low;
        r_high_ex   <= n_high_ex;
        r_mid       <= n_mid;
        r_key       <= n_key;
        r_result    <= n_result;
        r_out_index <= n_out_index;
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_index = $signed(r_out_index);

endmodule

@@ design/stbs_table_ram.sv @@
module stbs_table_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: a write cycle does not read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/stbs_checker.sv @@
`include "sorted_table_binary_search_top_assert.svh"

module stbs_props
    import stbs_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      i_req_type,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [OUT_W-1:0]   o_match_index
);

    // A stalled result keeps its value.
    `STBS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_match_index), "result changed while stalled")

    // A search transfer starts a multi-cycle search.
    `STBS_ASSERT(a_search_busy, i_in_valid && o_in_ready && (i_req_type == REQ_SEARCH) |=> !o_in_ready, "ready right after a search transfer")

    // A write transfer leaves the request side ready.
    `STBS_ASSERT(a_write_ready, i_in_valid && o_in_ready && (i_req_type == REQ_WRITE) |=> o_in_ready, "not ready after a write transfer")

    // A result is either not-found or an index inside the table.
    `STBS_ASSERT(a_index_range, o_out_valid |-> (o_match_index == $signed(NOT_FOUND)) || (32'($unsigned(o_match_index)) < TABLE_DEPTH), "result index out of range")

    // Reset empties the output register.
    `STBS_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind sorted_table_binary_search_top stbs_props u_stbs_props (.*);

@@ verif/stbs_checker.sv @@
module stbs_checker
    import stbs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_req_type,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic signed [VALUE_W-1:0] i_entry_value,
    input  logic signed [VALUE_W-1:0] i_search_key,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [OUT_W-1:0]   i_match_index,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [COUNT_W-1:0]        i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_hits
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] key;
        logic [OUT_W-1:0]   index;
    } t_lookup;

    // Shadow copy of the table and of entry_count, kept in step with the
    // transfers seen on the request and configuration channels.
    logic signed [VALUE_W-1:0] entries [TABLE_DEPTH];
    logic [COUNT_W-1:0]        live_count;
    t_lookup                   lookups_due [$];

    int fails   = 0;
    int pending = 0;
    int checked = 0;
    int hits    = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_hits       = hits;

    // Binary search with the same probe order as the block: the first probe
    // that matches wins, so duplicates resolve to whichever one is hit first.
    function automatic logic [OUT_W-1:0] locate(input logic signed [VALUE_W-1:0] key);
        int lo;
        int hi;
        int mid;
        int span;
        span = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count);
        lo = 0;
        hi = span - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid[ADDR_W-1:0]] == key) begin
                return mid[OUT_W-1:0];
            end else if (key < entries[mid[ADDR_W-1:0]]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return NOT_FOUND;
    endfunction

    always @(posedge i_clk) begin
        t_lookup due;
        if (!i_rst_n) begin
            live_count = '0;
            lookups_due.delete();
        end else begin
            // Results are matched first: a search taken at this edge cannot
            // have its answer out at the same edge.
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (lookups_due.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("stray result %0d with no search outstanding",
                                 i_match_index);
                    end
                end else begin
                    due = lookups_due.pop_front();
                    if (due.index != NOT_FOUND) begin
                        hits++;
                    end
                    if (i_match_index !== due.index) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display("search for key %0d: expected index %0d, got %0d",
                                     $signed(due.key), $signed(due.index),
                                     i_match_index);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                live_count = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_WRITE) begin
                    entries[i_entry_index] = i_entry_value;
                end else begin
                    due.key   = i_search_key;
                    due.index = locate(i_search_key);
                    lookups_due.push_back(due);
                end
            end
        end
        pending = lookups_due.size();
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import stbs_pkg::*;

    // A search needs at most eleven probes; the pause before a count change
    // and at the end covers a full search with some margin.
    localparam int SETTLE_CYCLES = 32;
    localparam int ITEM_GOAL     = 1700;
    localparam int LIMIT_CYCLES  = 600000;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_req_type;
    logic [INDEX_W-1:0]        i_entry_index;
    logic signed [VALUE_W-1:0] i_entry_value;
    logic signed [VALUE_W-1:0] i_search_key;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [OUT_W-1:0]   o_match_index;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [COUNT_W-1:0]        i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int hits;

    // Values last written to each table position, used only to choose
    // search keys that land on, next to, or far away from stored entries.
    logic signed [VALUE_W-1:0] written_values [TABLE_DEPTH];
    // While calm is set neither side inserts idle cycles.
    bit calm = 1'b0;
    int items = 0;
    int writes = 0;
    int searches = 0;
    int settings = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sorted_table_binary_search_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_match_index (o_match_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // The checker watches all three channels beside the block, predicts
    // every search answer and reports the number of failures back here.
    stbs_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_match_index (o_match_index),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_hits        (hits)
    );

    // The result side stalls about a third of the time, except in the calm
    // stretch. Changing ready at the falling edge keeps it stable around
    // every rising edge.
    always @(negedge i_clk) begin
        i_out_ready = calm || ($urandom_range(0, 99) >= 33);
    end

    // Presents one request and returns at the rising edge where it is
    // transferred. Valid stays high from one request to the next unless a
    // random gap is inserted, so back-to-back transfers are exercised too.
    task automatic push_req(input logic                      kind,
                            input logic [INDEX_W-1:0]        index,
                            input logic signed [VALUE_W-1:0] value,
                            input logic signed [VALUE_W-1:0] key);
        @(negedge i_clk);
        calm = (items >= 900) && (items < 1250);
        while (!calm && ($urandom_range(0, 99) < 33)) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_req_type    = kind;
        i_entry_index = index;
        i_entry_value = value;
        i_search_key  = key;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items++;
        if (kind == REQ_WRITE) begin
            writes++;
        end else begin
            searches++;
        end
    endtask

    task automatic store_entry(input int index, input logic signed [VALUE_W-1:0] value);
        written_values[index] = value;
        push_req(REQ_WRITE, index[INDEX_W-1:0], value, $urandom);
    endtask

    task automatic lookup(input logic signed [VALUE_W-1:0] key);
        push_req(REQ_SEARCH, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, key);
    endtask

    // entry_count may only change while the block is idle: the request
    // channel is dropped, every search answer must have come back, and a
    // write that is still finishing gets time to retire.
    task automatic set_entry_count(input logic [COUNT_W-1:0] count);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = count;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        settings++;
    endtask

    // Writes positions 0 to span-1 in ascending order. A sparse table spreads
    // over the whole signed range; a dense one uses steps of 0 to 3, which
    // gives duplicates and clamps against the top of the range.
    task automatic fill_ascending(input int span);
        longint level;
        longint stride_cap;
        if ($urandom_range(0, 3) == 0) begin
            stride_cap = 3;
            level      = longint'($urandom) - 64'sd2147483648;
        end else begin
            stride_cap = 64'sd4294967296 / (span + 1);
            level      = -64'sd2147483648 + longint'($urandom_range(0, 32'(stride_cap)));
        end
        for (int pos = 0; pos < span; pos++) begin
            if (level > 64'sd2147483647) begin
                level = 64'sd2147483647;
            end
            store_entry(pos, level[VALUE_W-1:0]);
            level += longint'($urandom_range(0, 32'(stride_cap)));
        end
    endtask

    // Most keys are stored values or their neighbors, so searches run all
    // the way down the probe path; the rest are extremes and random values.
    function automatic logic signed [VALUE_W-1:0] pick_key(input int span);
        int roll;
        int pos;
        roll = $urandom_range(0, 99);
        if (span == 0 || roll < 10) begin
            return $urandom;
        end
        pos = $urandom_range(0, span - 1);
        if (roll < 60) begin
            return written_values[pos];
        end else if (roll < 80) begin
            return ($urandom_range(0, 1) != 0) ? written_values[pos] + 1
                                               : written_values[pos] - 1;
        end else if (roll < 90) begin
            return ($urandom_range(0, 1) != 0) ? VALUE_MAX : VALUE_MIN;
        end
        return $urandom;
    endfunction

    initial begin
        int count;
        int span;
        int rounds;
        int phase;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_WRITE;
        i_entry_index = '0;
        i_entry_value = '0;
        i_search_key  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Right after reset the count is zero, so the first
        // search must come back as not found without touching the table.
        lookup(32'sd0);

        // Three entries holding the smallest, zero and the largest value:
        // each is found at its own index, and keys between them miss.
        set_entry_count(11'd3);
        store_entry(0, VALUE_MIN);
        store_entry(1, 32'sd0);
        store_entry(2, VALUE_MAX);
        lookup(VALUE_MIN);
        lookup(32'sd0);
        lookup(VALUE_MAX);
        lookup(VALUE_MIN + 1);
        lookup(-32'sd1);
        // The last table position with alternating bits; it lies outside the
        // searched range, so the answers above and below must not see it.
        store_entry(TABLE_DEPTH - 1, 32'sh5555_5555);
        lookup(32'sh5555_5555);

        // A single entry: the first probe decides.
        set_entry_count(11'd1);
        lookup(VALUE_MIN);
        lookup(VALUE_MAX);

        // Two equal entries: the first probe lands on index 0 and wins.
        set_entry_count(11'd2);
        store_entry(1, VALUE_MIN);
        lookup(VALUE_MIN);
        lookup(32'shAAAA_AAAA);

        // Random part, in phases of one count setting each. The first phase
        // fills the whole table so that any count is safe to search later;
        // the second uses the largest count the register can hold, which
        // must behave as the full table. After that most phases are small
        // freshly filled tables, with an occasional empty or large one.
        phase = 0;
        while (items < ITEM_GOAL) begin
            rounds = $urandom_range(15, 45);
            if (phase == 0) begin
                count  = TABLE_DEPTH;
                rounds = 80;
            end else if (phase == 1) begin
                count = (1 << COUNT_W) - 1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       count = 0;
                    1:       count = $urandom_range(513, (1 << COUNT_W) - 1);
                    default: count = $urandom_range(1, 48);
                endcase
            end
            span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            set_entry_count(count[COUNT_W-1:0]);
            if (phase == 0 || (phase > 1 && count <= 48)) begin
                fill_ascending(span);
            end
            for (int n = 0; n < rounds; n++) begin
                // Now and then a stray write lands anywhere and may break the
                // ascending order; the answers must still follow the probes.
                if ($urandom_range(0, 99) < 6) begin
                    store_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
                end else begin
                    lookup(pick_key(span));
                end
            end
            phase++;
        end

        // Drain: drop the request channel, wait for the last answer, then
        // keep watching a while so that any extra result is caught.
        @(negedge i_clk);
        i_in_valid = 1'b0;
        calm = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d table writes and %0d searches over %0d count settings.",
                 writes, searches, settings);
        $display("Checked %0d answers, %0d of them found entries; %0d failures.",
                 checked, hits, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a block that hangs or never answers.
    initial begin
        #(20 * LIMIT_CYCLES);
        $display("Timed out with %0d answers still outstanding.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
